FILE: sv/mrsr_pkg.sv
// ----------------------------------------------------------------------------
// mrsr_pkg
// Shared types and constants of the Markov ring signal router.
// ----------------------------------------------------------------------------
package mrsr_pkg;

  localparam int unsigned CH_W     = 4;
  localparam int unsigned SMP_W    = 16;
  localparam int unsigned DRAW_W   = 16;
  localparam int unsigned POS_W    = 2;
  localparam int unsigned PROB_W   = 17;
  localparam int unsigned NUM_PROBS = 8;
  localparam int unsigned PIDX_W   = 3;

  localparam logic [PROB_W-1:0] Q16_ONE    = 17'd65536;
  localparam logic [PROB_W-1:0] PROB_RESET = 17'd21824;
  localparam logic signed [SMP_W-1:0] TRIG_HIGH = 16'sd2048;
  localparam logic signed [SMP_W-1:0] TRIG_LOW  = 16'sd0;

  // Ring positions.
  localparam logic [POS_W-1:0] POS_A = 2'd0;

  // Backward and forward probability of one ring state.
  typedef struct packed {
    logic [PROB_W-1:0] pb;
    logic [PROB_W-1:0] pf;
  } prob_pair_t;

  function automatic logic [PROB_W-1:0] clamp_prob(input logic [PROB_W-1:0] p);
    clamp_prob = (p > Q16_ONE) ? Q16_ONE : p;
  endfunction

endpackage

FILE: sv/mrsr_step_decide.sv
// ----------------------------------------------------------------------------
// mrsr_step_decide
// Chooses forward, backward or stay for one trigger edge by comparing the
// scaled random draw against the cumulative probabilities.
// ----------------------------------------------------------------------------
module mrsr_step_decide (
  input  mrsr_pkg::prob_pair_t                probs,
  input  logic [mrsr_pkg::POS_W-1:0]          pos,
  input  logic [mrsr_pkg::DRAW_W-1:0]         draw,
  output logic [mrsr_pkg::POS_W-1:0]          pos_next
);

  logic [mrsr_pkg::PROB_W-1:0] pb;
  logic [mrsr_pkg::PROB_W-1:0] pf;
  logic [mrsr_pkg::PROB_W:0]   sum;
  logic [mrsr_pkg::PROB_W:0]   scale;
  logic [33:0]                 lhs;
  logic [33:0]                 fwd_lim;
  logic [33:0]                 bwd_lim;

  always_comb begin
    pb    = mrsr_pkg::clamp_prob(probs.pb);
    pf    = mrsr_pkg::clamp_prob(probs.pf);
    sum   = {1'b0, pb} + {1'b0, pf};
    // Scaling by the sum, when it exceeds one, is folded into the draw side of the comparison.
    scale = (sum > {1'b0, mrsr_pkg::Q16_ONE}) ? sum : {1'b0, mrsr_pkg::Q16_ONE};
    lhs     = 34'({18'd0, draw} * {16'd0, scale});
    fwd_lim = {1'b0, pf, 16'd0};
    bwd_lim = {sum, 16'd0};
    if (lhs < fwd_lim) begin
      pos_next = pos + 2'd1;
    end else if (lhs < bwd_lim) begin
      pos_next = pos - 2'd1;
    end else begin
      pos_next = pos;
    end
  end

endmodule

FILE: sv/markov_ring_signal_router_core.sv
// ----------------------------------------------------------------------------
// markov_ring_signal_router_core
// Per-channel four-state Markov ring with a Schmitt trigger that routes one
// of four signals to the output.
// ----------------------------------------------------------------------------
// A word is accepted every cycle while the output register is free or being
// drained. A word first reads the channel's state from a registered-read state
// memory into stage one; stage one then runs the trigger and step decision,
// writes the state back and loads the output register. Back-to-back words
// for the same channel are served by a bypass of the state being written.
// State resets to state A with the trigger low through per-entry valid bits,
// so no clearing pass is needed. Words whose channel is at or above
// NUM_CHANNELS touch no state and return state A with signal A and no step.
module markov_ring_signal_router_core #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata fields from bit 0: trig_level, sig_a, sig_b, sig_c, sig_d, random_draw
  input  logic [95:0]  in_tdata,
  // tuser fields from bit 0: channel
  input  logic [3:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata fields from bit 0: ring_state, routed_signal, stepped, zero fill
  output logic [23:0]  out_tdata,
  // tuser fields from bit 0: channel_out
  output logic [3:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_idx,
  input  logic [16:0]  cfg_data
);

  localparam int unsigned CH_AW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CH_EXTW = (CH_AW > mrsr_pkg::CH_W) ? CH_AW : mrsr_pkg::CH_W;
  localparam int unsigned ST_W    = mrsr_pkg::POS_W + 1;

  // Configuration registers.
  logic [mrsr_pkg::PROB_W-1:0] probs_r [mrsr_pkg::NUM_PROBS];

  // State memory: bit 2 is the trigger flag, bits 1:0 the ring position.
  logic [ST_W-1:0]          mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]  vld_r;
  logic [ST_W-1:0]          rd_mem_r;
  logic                     rd_vld_r;

  // Stage one.
  logic                          s1_v_r;
  logic [mrsr_pkg::CH_W-1:0]     s1_ch_r;
  logic                          s1_inr_r;
  logic signed [mrsr_pkg::SMP_W-1:0] s1_trig_r;
  logic [mrsr_pkg::SMP_W-1:0]    s1_sig_r [4];
  logic [mrsr_pkg::DRAW_W-1:0]   s1_draw_r;
  logic                          byp_r;
  logic [ST_W-1:0]               byp_data_r;

  // Output register.
  logic                          out_v_r;
  logic [mrsr_pkg::CH_W-1:0]     out_ch_r;
  logic [mrsr_pkg::POS_W-1:0]    out_pos_r;
  logic [mrsr_pkg::SMP_W-1:0]    out_sig_r;
  logic                          out_step_r;

  logic                          s1_adv;
  logic                          in_acc;
  logic [mrsr_pkg::CH_W-1:0]     in_ch;
  logic [CH_EXTW-1:0]            in_ch_ext;
  logic [CH_AW-1:0]              in_idx;
  logic [CH_AW-1:0]              s1_idx;
  logic [CH_EXTW-1:0]            s1_ch_ext;
  logic                          in_inr;
  logic                          byp_nxt;

  logic [ST_W-1:0]               cur_st;
  logic [mrsr_pkg::POS_W-1:0]    cur_pos;
  logic                          armed_nxt;
  logic                          edge_seen;
  logic [mrsr_pkg::POS_W-1:0]    dec_pos;
  logic [mrsr_pkg::POS_W-1:0]    new_pos;
  logic [ST_W-1:0]               new_st;
  mrsr_pkg::prob_pair_t          sel_probs;

  assign s1_adv    = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign in_ch     = in_tuser;
  assign in_ch_ext = CH_EXTW'(in_ch);
  assign in_idx    = in_ch_ext[CH_AW-1:0];
  assign in_inr    = 32'(in_ch) < NUM_CHANNELS;
  assign s1_ch_ext = CH_EXTW'(s1_ch_r);
  assign s1_idx    = s1_ch_ext[CH_AW-1:0];

  // A word that follows one of the same channel reads stale memory data.
  assign byp_nxt = s1_v_r && s1_inr_r && in_inr && (s1_ch_r == in_ch);

  always_comb begin
    if (byp_r) begin
      cur_st = byp_data_r;
    end else if (rd_vld_r) begin
      cur_st = rd_mem_r;
    end else begin
      cur_st = '0;
    end
    cur_pos   = cur_st[mrsr_pkg::POS_W-1:0];
    armed_nxt = cur_st[ST_W-1];
    edge_seen = 1'b0;
    if (cur_st[ST_W-1]) begin
      if (s1_trig_r <= mrsr_pkg::TRIG_LOW) begin
        armed_nxt = 1'b0;
      end
    end else if (s1_trig_r >= mrsr_pkg::TRIG_HIGH) begin
      armed_nxt = 1'b1;
      edge_seen = s1_inr_r;
    end
    sel_probs.pb = probs_r[{cur_pos, 1'b0}];
    sel_probs.pf = probs_r[{cur_pos, 1'b1}];
  end

  mrsr_step_decide u_decide (
    .probs    (sel_probs),
    .pos      (cur_pos),
    .draw     (s1_draw_r),
    .pos_next (dec_pos)
  );

  always_comb begin
    if (!s1_inr_r) begin
      new_pos = mrsr_pkg::POS_A;
    end else if (edge_seen) begin
      new_pos = dec_pos;
    end else begin
      new_pos = cur_pos;
    end
    new_st = {armed_nxt, new_pos};
  end

  // Configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mrsr_pkg::NUM_PROBS; i++) begin
        probs_r[i] <= mrsr_pkg::PROB_RESET;
      end
    end else if (cfg_we) begin
      probs_r[cfg_idx] <= cfg_data;
    end
  end

  // State memory with registered read.
  always_ff @(posedge clk) begin
    if (s1_v_r && s1_adv && s1_inr_r) begin
      mem[s1_idx] <= new_st;
    end
    if (in_acc && in_inr) begin
      rd_mem_r <= mem[in_idx];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      rd_vld_r <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      if (s1_v_r && s1_adv && s1_inr_r) begin
        vld_r[s1_idx] <= 1'b1;
      end
      if (in_acc) begin
        rd_vld_r <= in_inr && vld_r[in_idx];
        byp_r    <= byp_nxt;
      end
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch_r     <= in_ch;
      s1_inr_r    <= in_inr;
      s1_trig_r   <= in_tdata[15:0];
      s1_sig_r[0] <= in_tdata[31:16];
      s1_sig_r[1] <= in_tdata[47:32];
      s1_sig_r[2] <= in_tdata[63:48];
      s1_sig_r[3] <= in_tdata[79:64];
      s1_draw_r   <= in_tdata[95:80];
      byp_data_r  <= new_st;
    end
    if (s1_v_r && s1_adv) begin
      out_ch_r   <= s1_ch_r;
      out_pos_r  <= new_pos;
      out_sig_r  <= s1_sig_r[new_pos];
      out_step_r <= edge_seen;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_ch_r;
  assign out_tdata  = {5'd0, out_step_r, out_sig_r, out_pos_r};

  // Assertions.
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!s1_v_r || s1_adv))
    else $error("word accepted while stage one is stalled");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> s1_v_r)
    else $error("stage one word lost during output stall");

  a_bypass_source: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && byp_nxt) |=> (byp_r && s1_v_r && s1_inr_r))
    else $error("bypass taken without an in-range predecessor");

  a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_adv && !s1_inr_r) |=>
      (out_v_r && out_pos_r == mrsr_pkg::POS_A && !out_step_r))
    else $error("out-of-range channel produced a step");

endmodule

FILE: tb/markov_ring_signal_router_core_test.sv
// ----------------------------------------------------------------------------
// markov_ring_signal_router_core_test
// Self-checking bench for the Markov ring signal router. Sample words are
// queued, driven through the input stream with random gaps and compared
// against a cycle-free model of the per-channel trigger and ring step.
// Probability registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module markov_ring_signal_router_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_CH = 16;
  localparam longint unsigned ONE = mrsr_pkg::Q16_ONE;
  localparam int DRAIN_LIMIT = 200000;
  localparam int LONG_HOLD = 200;

  localparam logic [mrsr_pkg::POS_W-1:0] POS_B = 2'd1;
  localparam logic [mrsr_pkg::POS_W-1:0] POS_C = 2'd2;

  // Extreme signal sets, packed d, c, b, a from the top.
  localparam logic [63:0] SIGS_EXT1 = {16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};
  localparam logic [63:0] SIGS_EXT2 = {16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF};

  typedef enum logic [mrsr_pkg::PIDX_W-1:0] {
    PROB_A_TO_D, PROB_A_TO_B, PROB_B_TO_A, PROB_B_TO_C,
    PROB_C_TO_B, PROB_C_TO_D, PROB_D_TO_C, PROB_D_TO_A
  } prob_idx_e;

  typedef enum int {
    SET_ALL_ZERO, SET_ALL_ONE, SET_ALL_OVER, SET_RANDOM_Q16,
    SET_RANDOM_EXTREME, SET_FORWARD_ONLY, SET_RANDOM_FULL
  } setting_e;

  typedef struct packed {
    logic [mrsr_pkg::CH_W-1:0]          channel;
    logic [mrsr_pkg::DRAW_W-1:0]        draw;
    logic [mrsr_pkg::SMP_W-1:0]         sig_d;
    logic [mrsr_pkg::SMP_W-1:0]         sig_c;
    logic [mrsr_pkg::SMP_W-1:0]         sig_b;
    logic [mrsr_pkg::SMP_W-1:0]         sig_a;
    logic signed [mrsr_pkg::SMP_W-1:0]  trig_level;
  } sample_word_t;

  typedef struct packed {
    logic [mrsr_pkg::CH_W-1:0]   channel;
    logic [mrsr_pkg::POS_W-1:0]  state;
    logic [mrsr_pkg::SMP_W-1:0]  routed;
    logic                        stepped;
  } route_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;
  logic [3:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [23:0]  out_tdata;
  logic [3:0]   out_tuser;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_idx = '0;
  logic [16:0]  cfg_data = '0;

  // Model state and generator bookkeeping.
  logic [mrsr_pkg::PROB_W-1:0] prob_reg [mrsr_pkg::NUM_PROBS];
  logic [mrsr_pkg::POS_W-1:0]  ring_pos [NUM_CH];
  logic                        trig_armed [NUM_CH];
  logic                        gen_armed [NUM_CH];
  int unsigned                 last_ch = 0;

  sample_word_t  pending_words [$];
  route_result_t expected_routes [$];
  sample_word_t  held_word;
  bit            word_held = 1'b0;
  int            send_gap = 0;
  int            stall_left = 0;
  int            hold_left = 0;
  int            results_seen = 0;
  int            mismatches = 0;
  bit            idling_on = 1'b0;

  markov_ring_signal_router_core #(
    .NUM_CHANNELS(NUM_CH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register 2s holds the backward and 2s+1 the forward probability of state s.
  function automatic prob_idx_e prob_index(logic [1:0] s, logic fwd);
    return prob_idx_e'({s, fwd});
  endfunction

  function automatic longint unsigned clamped_prob(prob_idx_e idx);
    return (prob_reg[idx] > ONE) ? ONE : longint'(prob_reg[idx]);
  endfunction

  function automatic route_result_t predict_route(sample_word_t w);
    route_result_t r;
    logic [mrsr_pkg::POS_W-1:0] pos;
    logic rise;
    longint unsigned pb, pf, sum, scale, lhs;
    pos = mrsr_pkg::POS_A;
    rise = 1'b0;
    if (w.channel < NUM_CH) begin
      pos = ring_pos[w.channel];
      if (trig_armed[w.channel]) begin
        if (w.trig_level <= mrsr_pkg::TRIG_LOW) trig_armed[w.channel] = 1'b0;
      end else if (w.trig_level >= mrsr_pkg::TRIG_HIGH) begin
        trig_armed[w.channel] = 1'b1;
        rise = 1'b1;
      end
      if (rise) begin
        pb = clamped_prob(prob_index(pos, 1'b0));
        pf = clamped_prob(prob_index(pos, 1'b1));
        sum = pb + pf;
        scale = (sum > ONE) ? sum : ONE;
        lhs = longint'(w.draw) * scale;
        // Cross-multiplied form of r < Pf/S and r < (Pf+Pb)/S.
        if (lhs < pf * ONE) pos = pos + 2'd1;
        else if (lhs < sum * ONE) pos = pos - 2'd1;
      end
      ring_pos[w.channel] = pos;
    end
    r.channel = w.channel;
    r.state = pos;
    r.stepped = rise;
    case (pos)
      mrsr_pkg::POS_A: r.routed = w.sig_a;
      POS_B:           r.routed = w.sig_b;
      POS_C:           r.routed = w.sig_c;
      default:         r.routed = w.sig_d;
    endcase
    return r;
  endfunction

  // Mostly no gap, some short ones and a few long ones.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] rand_trig(logic armed);
    int r;
    r = $urandom_range(0, 9);
    if (r == 8) return 16'($urandom);
    if (r == 9) return 16'($urandom_range(1, 2047));
    if (!armed) begin
      case ($urandom_range(0, 3))
        0:       return mrsr_pkg::TRIG_HIGH;
        1:       return 16'sh7FFF;
        default: return 16'($urandom_range(2048, 32767));
      endcase
    end
    case ($urandom_range(0, 3))
      0:       return mrsr_pkg::TRIG_LOW;
      1:       return 16'sh8000;
      default: return 16'(-int'($urandom_range(0, 32768)));
    endcase
  endfunction

  function automatic logic [15:0] rand_sig();
    if ($urandom_range(0, 9) != 0) return 16'($urandom);
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Uniform draws, the two ends, and draws right at a decision boundary.
  function automatic logic [15:0] rand_draw();
    int r;
    logic [1:0] s;
    longint unsigned pb, pf, sum, scale;
    longint target;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom);
    if (r == 6) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    s = 2'($urandom_range(0, 3));
    pb = clamped_prob(prob_index(s, 1'b0));
    pf = clamped_prob(prob_index(s, 1'b1));
    sum = pb + pf;
    scale = (sum > ONE) ? sum : ONE;
    target = longint'((($urandom_range(0, 1) != 0) ? pf : sum) * ONE / scale);
    target = target + longint'($urandom_range(0, 2)) - 1;
    if (target < 0) target = 0;
    if (target > 65535) target = 65535;
    return 16'(target);
  endfunction

  task automatic add_word(input int unsigned ch, input logic signed [15:0] trig,
                          input logic [63:0] sigs, input logic [15:0] draw);
    sample_word_t w;
    w.channel = 4'(ch);
    w.trig_level = trig;
    {w.sig_d, w.sig_c, w.sig_b, w.sig_a} = sigs;
    w.draw = draw;
    if (gen_armed[ch] && trig <= mrsr_pkg::TRIG_LOW) gen_armed[ch] = 1'b0;
    else if (!gen_armed[ch] && trig >= mrsr_pkg::TRIG_HIGH) gen_armed[ch] = 1'b1;
    pending_words.push_back(w);
    last_ch = ch;
  endtask

  // Most words flip the channel's trigger so that edges are frequent; the rest
  // are noise that may or may not cross a threshold.
  task automatic queue_random(input int count);
    int unsigned ch;
    for (int i = 0; i < count; i++) begin
      ch = ($urandom_range(0, 9) < 3) ? last_ch : $urandom_range(0, NUM_CH - 1);
      add_word(ch, rand_trig(gen_armed[ch]),
               {rand_sig(), rand_sig(), rand_sig(), rand_sig()}, rand_draw());
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("[%0t] result %0d: %s expected %0h, got %0h",
             $realtime, results_seen, what, want, got);
    mismatches++;
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    while ((pending_words.size() != 0 || word_held || expected_routes.size() != 0)
           && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (expected_routes.size() != 0 || pending_words.size() != 0) begin
      report_mismatch("words still outstanding", 0, expected_routes.size());
      expected_routes.delete();
      pending_words.delete();
    end
  endtask

  task automatic write_prob(input prob_idx_e idx, input logic [16:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    prob_reg[idx] = value;
  endtask

  task automatic apply_setting(input setting_e setting);
    logic [16:0] value;
    for (int i = 0; i < mrsr_pkg::NUM_PROBS; i++) begin
      case (setting)
        SET_ALL_ZERO: value = '0;
        SET_ALL_ONE:  value = mrsr_pkg::Q16_ONE;
        SET_ALL_OVER: value = 17'h1FFFF;
        SET_RANDOM_Q16: value = 17'($urandom_range(0, 65536));
        SET_RANDOM_EXTREME: begin
          case ($urandom_range(0, 6))
            0: value = 17'd0;
            1: value = 17'd1;
            2: value = 17'd32768;
            3: value = 17'd65535;
            4: value = mrsr_pkg::Q16_ONE;
            5: value = 17'd65537;
            default: value = 17'h1FFFF;
          endcase
        end
        SET_FORWARD_ONLY: value = (i % 2 == 1) ? mrsr_pkg::Q16_ONE : 17'd0;
        default: value = 17'($urandom);
      endcase
      write_prob(prob_idx_e'(i), value);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sender: holds one word on the bus until it is taken, then maybe idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      word_held = 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_routes.push_back(predict_route(held_word));
        word_held = 1'b0;
      end
      if (!word_held) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() != 0) begin
          held_word = pending_words.pop_front();
          word_held = 1'b1;
          in_tdata <= {held_word.draw, held_word.sig_d, held_word.sig_c,
                       held_word.sig_b, held_word.sig_a, held_word.trig_level};
          in_tuser <= held_word.channel;
          send_gap = pick_idle();
        end
      end
      in_tvalid <= word_held;
    end
  end

  // Receiver: checks every accepted word and throttles out_tready.
  always @(posedge clk) begin
    route_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_routes.size() == 0) begin
          report_mismatch("unexpected word, channel", 0, out_tuser);
        end else begin
          want = expected_routes.pop_front();
          if (out_tuser != want.channel)
            report_mismatch("channel_out", want.channel, out_tuser);
          if (out_tdata[1:0] != want.state)
            report_mismatch("ring_state", want.state, out_tdata[1:0]);
          if (out_tdata[17:2] != want.routed)
            report_mismatch("routed_signal", want.routed, out_tdata[17:2]);
          if (out_tdata[18] != want.stepped)
            report_mismatch("stepped", want.stepped, out_tdata[18]);
          if (out_tdata[23:19] != '0)
            report_mismatch("zero fill", 0, out_tdata[23:19]);
        end
        results_seen++;
        // Two long back-pressure windows so the pipeline fills and stalls input.
        if (results_seen == 100 || results_seen == 1000) hold_left = LONG_HOLD;
        else stall_left = pick_idle();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < mrsr_pkg::NUM_PROBS; i++) prob_reg[i] = mrsr_pkg::PROB_RESET;
    for (int i = 0; i < NUM_CH; i++) begin
      ring_pos[i] = mrsr_pkg::POS_A;
      trig_armed[i] = 1'b0;
      gen_armed[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset probabilities: forward below 21824, back below 43648, else stay.
    // Channel 3 walks the Schmitt trigger thresholds and wraps the ring both ways.
    add_word(3, 16'sd2047, SIGS_EXT1, 16'd0);
    add_word(3, mrsr_pkg::TRIG_HIGH, SIGS_EXT1, 16'd0);
    add_word(3, 16'sh7FFF, SIGS_EXT2, 16'd0);
    add_word(3, 16'sd1, SIGS_EXT1, 16'd0);
    add_word(3, mrsr_pkg::TRIG_LOW, SIGS_EXT2, 16'hFFFF);
    add_word(3, 16'sh7FFF, SIGS_EXT1, 16'd30000);
    add_word(3, 16'sh8000, SIGS_EXT2, 16'd0);
    add_word(3, mrsr_pkg::TRIG_HIGH, SIGS_EXT1, 16'hFFFF);
    add_word(3, -16'sd1, SIGS_EXT2, 16'd0);
    add_word(3, mrsr_pkg::TRIG_HIGH, SIGS_EXT1, 16'd30000);
    add_word(3, mrsr_pkg::TRIG_LOW, SIGS_EXT2, 16'd0);
    add_word(3, mrsr_pkg::TRIG_HIGH, SIGS_EXT2, 16'd0);
    add_word(3, 16'sh8000, SIGS_EXT1, 16'd0);
    add_word(0, 16'sh7FFF, SIGS_EXT2, 16'd0);
    add_word(15, mrsr_pkg::TRIG_HIGH, SIGS_EXT1, 16'd0);
    add_word(0, 16'sh8000, SIGS_EXT1, 16'hFFFF);
    // Channel 5 lands exactly on both decision boundaries.
    add_word(5, mrsr_pkg::TRIG_HIGH, SIGS_EXT1, 16'd21823);
    add_word(5, mrsr_pkg::TRIG_LOW, SIGS_EXT1, 16'd0);
    add_word(5, mrsr_pkg::TRIG_HIGH, SIGS_EXT2, 16'd21824);
    add_word(5, mrsr_pkg::TRIG_LOW, SIGS_EXT1, 16'd0);
    add_word(5, mrsr_pkg::TRIG_HIGH, SIGS_EXT1, 16'd43647);
    add_word(5, mrsr_pkg::TRIG_LOW, SIGS_EXT2, 16'd0);
    add_word(5, mrsr_pkg::TRIG_HIGH, SIGS_EXT2, 16'd43648);
    while (pending_words.size() != 0) @(posedge clk);

    idling_on = 1'b1;
    queue_random(250);
    wait_idle();

    for (int p = SET_ALL_ZERO; p <= SET_RANDOM_FULL; p++) begin
      apply_setting(setting_e'(p));
      idling_on = (p != SET_ALL_OVER && p != SET_FORWARD_ONLY);
      queue_random(250);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/mrsr_pkg.sv
sv/mrsr_step_decide.sv
sv/markov_ring_signal_router_core.sv
tb/markov_ring_signal_router_core_test.sv
